### rtl/mhvt_pkg.sv
// ----------------------------------------------------------------------------
// mhvt_pkg
// Shared types and constants for the MIME header value tokenizer.
// ----------------------------------------------------------------------------
package mhvt_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_SPACE,
    CLS_SEMI,
    CLS_COMMA,
    CLS_EQ,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_QUOTE,
    CLS_NUL
  } chr_class_t;

  typedef enum logic [1:0] {
    PH_VALUE  = 2'd0,
    PH_NAME   = 2'd1,
    PH_PVALUE = 2'd2
  } phase_t;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_CHAR = 2'd1;
  localparam logic [1:0] EV_END  = 2'd2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
    chr_class_t cls;
  } item_t;

endpackage

### rtl/mhvt_if.sv
// ----------------------------------------------------------------------------
// mhvt_if
// Valid/ready channels for input bytes and tokenizer results.
// ----------------------------------------------------------------------------
interface mhvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_line;

  modport source (output valid, output char_byte, output end_of_line, input ready);
  modport sink   (input valid, input char_byte, input end_of_line, output ready);
endinterface

interface mhvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [1:0] role;
  logic [7:0] token_char;
  logic       line_done;

  modport source (output valid, output event_res, output role, output token_char,
                  output line_done, input ready);
  modport sink   (input valid, input event_res, input role, input token_char,
                  input line_done, output ready);
endinterface

### rtl/mhvt_front.sv
// ----------------------------------------------------------------------------
// mhvt_front
// Accepts input bytes, maps the terminator to NUL and classifies each byte.
// ----------------------------------------------------------------------------
module mhvt_front (
  input  logic              clk,
  input  logic              rst_n,
  mhvt_in_if.sink           in_ch,
  output logic              item_valid,
  input  logic              item_ready,
  output mhvt_pkg::item_t   item
);

  localparam logic [7:0] CHR_NUL    = 8'h00;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_LPAREN = 8'h28;
  localparam logic [7:0] CHR_RPAREN = 8'h29;
  localparam logic [7:0] CHR_COMMA  = 8'h2C;
  localparam logic [7:0] CHR_SEMI   = 8'h3B;
  localparam logic [7:0] CHR_EQ     = 8'h3D;

  logic                 item_valid_r;
  mhvt_pkg::item_t      item_r;
  logic [7:0]           chr;
  mhvt_pkg::chr_class_t cls;
  logic                 accept;

  assign chr = in_ch.end_of_line ? CHR_NUL : in_ch.char_byte;

  always_comb begin
    unique case (chr)
      CHR_NUL:    cls = mhvt_pkg::CLS_NUL;
      CHR_SPACE:  cls = mhvt_pkg::CLS_SPACE;
      CHR_QUOTE:  cls = mhvt_pkg::CLS_QUOTE;
      CHR_LPAREN: cls = mhvt_pkg::CLS_LPAREN;
      CHR_RPAREN: cls = mhvt_pkg::CLS_RPAREN;
      CHR_COMMA:  cls = mhvt_pkg::CLS_COMMA;
      CHR_SEMI:   cls = mhvt_pkg::CLS_SEMI;
      CHR_EQ:     cls = mhvt_pkg::CLS_EQ;
      default:    cls = mhvt_pkg::CLS_OTHER;
    endcase
  end

  assign in_ch.ready = !item_valid_r || item_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (accept) begin
      item_valid_r <= 1'b1;
    end else if (item_ready) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.char_byte   <= chr;
      item_r.end_of_line <= in_ch.end_of_line;
      item_r.cls         <= cls;
    end
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule

### rtl/mhvt_queue.sv
// ----------------------------------------------------------------------------
// mhvt_queue
// Small FIFO of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module mhvt_queue #(
  parameter int DEPTH = mhvt_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  mhvt_pkg::item_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output mhvt_pkg::item_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mhvt_pkg::item_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign wr_ready = count_r != CNT_FULL;
  assign rd_valid = count_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/mhvt_back.sv
// ----------------------------------------------------------------------------
// mhvt_back
// Tokenizer state update and registered result output.
// ----------------------------------------------------------------------------
module mhvt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  mhvt_pkg::item_t q_data,
  mhvt_out_if.source      out_ch
);

  mhvt_pkg::phase_t phase_r, phase_nxt;
  logic             in_comment_r, in_comment_nxt;
  logic             in_quote_r, in_quote_nxt;
  logic             skip_r, skip_nxt;

  logic             out_valid_r;
  logic [1:0]       event_res_r, event_res_nxt;
  logic [1:0]       role_r, role_nxt;
  logic [7:0]       token_char_r, token_char_nxt;
  logic             line_done_r;

  logic             take;
  logic             skip_mid;
  logic             end_cmt;
  logic             start_cmt;
  logic             end_quote;
  logic             start_quote;
  logic             dropped;
  logic             delim;
  logic             is_end;
  logic             is_char;

  assign q_ready = !out_valid_r || out_ch.ready;
  assign take    = q_valid && q_ready;

  // decode the byte against the current state
  always_comb begin
    skip_mid    = skip_r && (q_data.cls == mhvt_pkg::CLS_SPACE);
    end_cmt     = in_comment_r && (q_data.cls == mhvt_pkg::CLS_RPAREN);
    start_cmt   = !end_cmt && !in_comment_r && !in_quote_r
                  && (q_data.cls == mhvt_pkg::CLS_LPAREN);
    end_quote   = !end_cmt && !start_cmt && in_quote_r
                  && (q_data.cls == mhvt_pkg::CLS_QUOTE);
    start_quote = !end_cmt && !start_cmt && !end_quote && !in_quote_r && !in_comment_r
                  && (q_data.cls == mhvt_pkg::CLS_QUOTE);
    dropped     = end_cmt || start_cmt || end_quote || start_quote;
    unique case (phase_r)
      mhvt_pkg::PH_VALUE:  delim = (q_data.cls == mhvt_pkg::CLS_SEMI)
                                   || (q_data.cls == mhvt_pkg::CLS_COMMA)
                                   || (q_data.cls == mhvt_pkg::CLS_NUL);
      mhvt_pkg::PH_NAME:   delim = (q_data.cls == mhvt_pkg::CLS_EQ)
                                   || (q_data.cls == mhvt_pkg::CLS_NUL);
      mhvt_pkg::PH_PVALUE: delim = (q_data.cls == mhvt_pkg::CLS_SEMI)
                                   || (q_data.cls == mhvt_pkg::CLS_NUL);
      default:             delim = 1'b0;
    endcase
    is_end  = !dropped && !in_quote_r && !in_comment_r && delim;
    is_char = !dropped && !is_end && !in_comment_r && !skip_mid;
  end

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    in_comment_nxt = in_comment_r;
    in_quote_nxt   = in_quote_r;
    skip_nxt       = skip_r;
    if (take) begin
      skip_nxt = skip_mid;
      if (end_cmt) begin
        in_comment_nxt = 1'b0;
      end
      if (start_cmt) begin
        in_comment_nxt = 1'b1;
      end
      if (end_quote) begin
        in_quote_nxt = 1'b0;
      end
      if (start_quote) begin
        in_quote_nxt = 1'b1;
      end
      if (is_end) begin
        skip_nxt  = 1'b1;
        phase_nxt = (phase_r == mhvt_pkg::PH_NAME) ? mhvt_pkg::PH_PVALUE
                                                    : mhvt_pkg::PH_NAME;
      end
      if (q_data.end_of_line) begin
        phase_nxt      = mhvt_pkg::PH_VALUE;
        in_comment_nxt = 1'b0;
        in_quote_nxt   = 1'b0;
        skip_nxt       = 1'b1;
      end
    end
  end

  // result
  always_comb begin
    event_res_nxt  = mhvt_pkg::EV_NONE;
    role_nxt       = '0;
    token_char_nxt = '0;
    if (is_end) begin
      event_res_nxt = mhvt_pkg::EV_END;
      role_nxt      = phase_r;
    end else if (is_char) begin
      event_res_nxt  = mhvt_pkg::EV_CHAR;
      role_nxt       = phase_r;
      token_char_nxt = q_data.char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mhvt_pkg::PH_VALUE;
      in_comment_r <= 1'b0;
      in_quote_r   <= 1'b0;
      skip_r       <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      in_comment_r <= in_comment_nxt;
      in_quote_r   <= in_quote_nxt;
      skip_r       <= skip_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      event_res_r  <= event_res_nxt;
      role_r       <= role_nxt;
      token_char_r <= token_char_nxt;
      line_done_r  <= q_data.end_of_line;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_res  = event_res_r;
  assign out_ch.role       = role_r;
  assign out_ch.token_char = token_char_r;
  assign out_ch.line_done  = line_done_r;

endmodule

### rtl/mime_header_value_tokenizer_top.sv
// ----------------------------------------------------------------------------
// mime_header_value_tokenizer_top
// An input transaction passes through the front register, the queue and the
// result register before its result is valid. Throughput: one byte per cycle
// while the result channel is not stalled, set by the state update in the back part.
// Reset: synchronous active-low rst_n empties the queue and returns the
// tokenizer to the value phase with space skipping on.
// ----------------------------------------------------------------------------
module mime_header_value_tokenizer_top #(
  parameter int QUEUE_DEPTH = mhvt_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  mhvt_in_if.sink    in_ch,
  mhvt_out_if.source out_ch
);

  logic            front_valid;
  logic            front_ready;
  mhvt_pkg::item_t front_item;
  logic            q_valid;
  logic            q_ready;
  mhvt_pkg::item_t q_item;

  mhvt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  mhvt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_item)
  );

  mhvt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_item),
    .out_ch  (out_ch)
  );

endmodule

### rtl/mhvt_checker.sv
// ----------------------------------------------------------------------------
// mhvt_checker
// Port-level assertions for the tokenizer result channel.
// ----------------------------------------------------------------------------
module mhvt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_res,
  input logic [1:0] out_role,
  input logic [7:0] out_token_char,
  input logic       out_line_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res)
      && $stable(out_role) && $stable(out_token_char) && $stable(out_line_done))
    else $error("result changed while stalled");

  a_no_event_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == mhvt_pkg::EV_NONE) |-> (out_role == 2'd0)
      && (out_token_char == 8'd0))
    else $error("empty result carries role or character");

  a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == mhvt_pkg::EV_END) |-> (out_token_char == 8'd0)
      && (out_role != 2'd3))
    else $error("token end carries character or bad role");

  a_event_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_res == mhvt_pkg::EV_NONE)
      || (out_event_res == mhvt_pkg::EV_CHAR) || (out_event_res == mhvt_pkg::EV_END))
    else $error("illegal event code");

endmodule

bind mime_header_value_tokenizer_top mhvt_checker u_mhvt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_event_res  (out_ch.event_res),
  .out_role       (out_ch.role),
  .out_token_char (out_ch.token_char),
  .out_line_done  (out_ch.line_done)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the MIME header value tokenizer. A directed run covers
// leading spaces, comments, quotes, the delimiters of every phase, a data NUL,
// and the terminator in plain text, inside quotes and inside a comment. It is
// followed by random well-formed header lines, raw byte noise, a long output
// hold-off, a full drain pause and a final run with no idling. A local
// tokenizer predicts every result, and the results are checked in order,
// field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;

  typedef struct packed {
    logic [1:0] event_res;
    logic [1:0] role;
    logic [7:0] token_char;
    logic       line_done;
  } token_res_t;

  logic clk;
  logic rst_n;

  mhvt_in_if  in_ch ();
  mhvt_out_if out_ch ();

  mime_header_value_tokenizer_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // tokenizer state as the block should hold it
  mhvt_pkg::phase_t tok_phase = mhvt_pkg::PH_VALUE;
  logic   in_comment_q = 1'b0;
  logic   in_quote_q = 1'b0;
  logic   skip_space_q = 1'b1;

  token_res_t token_q[$];
  int         error_count = 0;
  int         items_sent = 0;
  bit         send_gaps = 1'b1;
  bit         sink_stalls = 1'b1;
  bit         hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic token_res_t predict_token(input logic [7:0] b, input logic eol);
    logic [7:0] c;
    logic       drop;
    logic       delim;
    token_res_t r;
    c = eol ? CH_NUL : b;
    r = '0;
    r.line_done = eol;
    drop = 1'b0;
    if (skip_space_q && c != CH_SPACE) skip_space_q = 1'b0;
    if (in_comment_q && c == CH_RPAREN) begin
      in_comment_q = 1'b0;
      drop = 1'b1;
    end else if (!in_comment_q && !in_quote_q && c == CH_LPAREN) begin
      in_comment_q = 1'b1;
      drop = 1'b1;
    end else if (in_quote_q && c == CH_QUOTE) begin
      in_quote_q = 1'b0;
      drop = 1'b1;
    end else if (!in_quote_q && !in_comment_q && c == CH_QUOTE) begin
      in_quote_q = 1'b1;
      drop = 1'b1;
    end
    case (tok_phase)
      mhvt_pkg::PH_VALUE:  delim = (c == CH_SEMI) || (c == CH_COMMA) || (c == CH_NUL);
      mhvt_pkg::PH_NAME:   delim = (c == CH_EQ) || (c == CH_NUL);
      mhvt_pkg::PH_PVALUE: delim = (c == CH_SEMI) || (c == CH_NUL);
      default:             delim = 1'b0;
    endcase
    if (!drop) begin
      if (!in_quote_q && !in_comment_q && delim) begin
        r.event_res = mhvt_pkg::EV_END;
        r.role = tok_phase;
        skip_space_q = 1'b1;
        if (tok_phase == mhvt_pkg::PH_NAME) tok_phase = mhvt_pkg::PH_PVALUE;
        else tok_phase = mhvt_pkg::PH_NAME;
      end else if (!in_comment_q && !skip_space_q) begin
        r.event_res = mhvt_pkg::EV_CHAR;
        r.role = tok_phase;
        r.token_char = c;
      end
    end
    if (eol) begin
      tok_phase = mhvt_pkg::PH_VALUE;
      in_comment_q = 1'b0;
      in_quote_q = 1'b0;
      skip_space_q = 1'b1;
    end
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eol);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_byte   <= b;
    in_ch.end_of_line <= eol;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    token_q.insert(token_q.size(), predict_token(b, eol));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic end_line();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (token_q.size() != 0);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126));
    while (c == CH_SEMI || c == CH_COMMA || c == CH_EQ || c == CH_LPAREN ||
           c == CH_RPAREN || c == CH_QUOTE);
    return c;
  endfunction

  task automatic send_spaces(input int max_n);
    repeat ($urandom_range(0, max_n)) send_byte(CH_SPACE, 1'b0);
  endtask

  // word, then maybe a quoted part or a comment, then more word
  task automatic send_token();
    logic [7:0] c;
    repeat ($urandom_range(0, 4)) send_byte(plain_char(), 1'b0);
    case ($urandom_range(0, 5))
      0: begin
        send_byte(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE);
          send_byte(c, 1'b0);
        end
        send_byte(CH_QUOTE, 1'b0);
      end
      1: begin
        send_byte(CH_LPAREN, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom_range(32, 126)); while (c == CH_RPAREN);
          send_byte(c, 1'b0);
        end
        send_byte(CH_RPAREN, 1'b0);
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) send_byte(plain_char(), 1'b0);
  endtask

  task automatic send_header_line();
    send_spaces(2);
    send_token();
    repeat ($urandom_range(0, 3)) begin
      send_byte(($urandom_range(0, 9) == 0) ? CH_COMMA : CH_SEMI, 1'b0);
      send_spaces(2);
      send_token();
      send_spaces(1);
      send_byte(CH_EQ, 1'b0);
      send_spaces(2);
      send_token();
    end
    end_line();
  endtask

  task automatic test_directed_line();
    send_text(" a(c)\"q;\",)");
    send_byte(8'hFF, 1'b0);
    send_text("=v;");
    send_byte(CH_NUL, 1'b0);
    send_byte(8'hA5, 1'b1);
  endtask

  task automatic test_eol_in_quote();
    send_text("\"x");
    end_line();
  endtask

  task automatic test_eol_in_comment();
    send_byte(CH_LPAREN, 1'b0);
    end_line();
  endtask

  task automatic test_random_lines(input int target);
    while (items_sent < target) send_header_line();
  endtask

  task automatic test_byte_noise(input int count);
    logic [7:0] specials[8];
    specials = '{CH_NUL, CH_SPACE, CH_QUOTE, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI,
                 CH_EQ};
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) end_line();
      else if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
      else send_byte(specials[$urandom_range(0, 7)], 1'b0);
    end
  endtask

  task automatic test_output_holdoff();
    send_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (4) send_header_line();
    send_gaps = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (3) send_header_line();
    drain_results();
    repeat (3) send_header_line();
  endtask

  task automatic test_no_idle(input int target);
    send_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random_lines(target);
  endtask

  // output side: random stalls, plus the long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    token_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %0h/%0h/%0h/%0h",
                 $time, out_ch.event_res, out_ch.role, out_ch.token_char,
                 out_ch.line_done);
        error_count++;
      end else begin
        want = token_q.pop_front();
        report_field("event_res", want.event_res, out_ch.event_res);
        report_field("role", want.role, out_ch.role);
        report_field("token_char", want.token_char, out_ch.token_char);
        report_field("line_done", want.line_done, out_ch.line_done);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.char_byte   <= 8'h00;
    in_ch.end_of_line <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_line();
    test_eol_in_quote();
    test_eol_in_comment();
    test_random_lines(1000);
    test_byte_noise(300);
    test_output_holdoff();
    test_drain_pause();
    test_no_idle(1650);

    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
